[hw/rtl/aes_block_encrypt_unit_defines.svh]
// Assertion macros for the AES encrypt unit.
`ifndef AES_BLOCK_ENCRYPT_UNIT_DEFINES_SVH
`define AES_BLOCK_ENCRYPT_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AESENC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aesenc check failed");

// Next-cycle implication, checked outside reset.
`define AESENC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aesenc check failed");

`endif

[hw/rtl/aesenc_pkg.sv]
`default_nettype none

package aesenc_pkg;

    localparam int NUM_CELLS = 14;

    // Configuration register indexes
    localparam logic [2:0] CFG_MODE   = 3'd0;
    localparam logic [2:0] CFG_KEY_0  = 3'd1;
    localparam logic [2:0] CFG_KEY_1  = 3'd2;
    localparam logic [2:0] CFG_KEY_2  = 3'd3;
    localparam logic [2:0] CFG_KEY_3  = 3'd4;

    // Key size modes
    localparam logic [1:0] MODE_128 = 2'd0;
    localparam logic [1:0] MODE_192 = 2'd1;

    typedef struct packed {
        logic       valid;
        logic [1:0] mode;
    } t_ctl;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] rcon(input logic [3:0] idx);
        logic [7:0] r;
        unique case (idx)
            4'd0:    r = 8'h01;
            4'd1:    r = 8'h02;
            4'd2:    r = 8'h04;
            4'd3:    r = 8'h08;
            4'd4:    r = 8'h10;
            4'd5:    r = 8'h20;
            4'd6:    r = 8'h40;
            4'd7:    r = 8'h80;
            4'd8:    r = 8'h1b;
            4'd9:    r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] num_rounds(input logic [1:0] mode);
        logic [3:0] n;
        unique case (mode)
            MODE_128: n = 4'd10;
            MODE_192: n = 4'd12;
            default:  n = 4'd14;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // SubBytes and ShiftRows; byte n sits at bits 127-8n downwards.
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, al;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            t[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            t[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            t[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

    // One key schedule word w[idx] from w[idx-1] and w[idx-nk].
    function automatic logic [31:0] key_word(input logic [5:0] idx, input logic [1:0] mode,
                                             input logic [31:0] prev, input logic [31:0] back);
        logic [11:0] prod;
        logic [4:0]  q;
        logic [4:0]  qm1;
        logic [3:0]  rm;
        logic [3:0]  ri;
        logic [31:0] t;
        prod = {6'd0, idx} * 12'd43;
        unique case (mode)
            MODE_128: begin
                q  = {1'b0, idx[5:2]};
                rm = {2'b00, idx[1:0]};
            end
            MODE_192: begin
                // idx / 6 through a reciprocal, exact for idx below 128
                q  = {1'b0, prod[11:8]};
                rm = 4'(idx - 6'({2'b00, prod[11:8]} * 6'd6));
            end
            default: begin
                q  = {2'b00, idx[5:3]};
                rm = {1'b0, idx[2:0]};
            end
        endcase
        qm1 = q - 5'd1;
        ri  = (qm1 >= 5'd10) ? 4'(qm1 - 5'd10) : qm1[3:0];
        if (rm == 4'd0) begin
            t = sub_word({prev[23:0], prev[31:24]}) ^ {rcon(ri), 24'h0};
        end else if (mode[1] && rm == 4'd4) begin
            t = sub_word(prev);
        end else begin
            t = prev;
        end
        return back ^ t;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/aesenc_cell.sv]
`default_nettype none

// One round: carries the state and an eight-word key window w[4r-4 .. 4r+3].
module aesenc_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [3:0]          i_round,
    input  logic                i_en,
    input  aesenc_pkg::t_ctl    i_ctl,
    input  logic [127:0]        i_state,
    input  logic [255:0]        i_keys,
    output aesenc_pkg::t_ctl    o_ctl,
    output logic [127:0]        o_state,
    output logic [255:0]        o_keys
);
    import aesenc_pkg::*;

    t_ctl          r_ctl;
    logic [127:0]  r_state;
    logic [255:0]  r_keys;
    logic [127:0]  n_state;
    logic [255:0]  n_keys;
    logic [31:0]   e [12];
    logic [31:0]   back;
    logic [5:0]    idx_base;
    logic [127:0]  rk;
    logic [127:0]  sr;
    logic [127:0]  mx;
    logic [3:0]    nr;

    always_comb begin
        idx_base = {i_round, 2'b00} + 6'd4;
        for (int k = 0; k < 8; k++) begin
            e[k] = i_keys[255 - 32 * k -: 32];
        end
        for (int j = 0; j < 4; j++) begin
            unique case (i_ctl.mode)
                MODE_128: back = e[4 + j];
                MODE_192: back = e[2 + j];
                default:  back = e[j];
            endcase
            e[8 + j] = key_word(6'(idx_base + 6'(j)), i_ctl.mode, e[7 + j], back);
        end
        rk     = {e[4], e[5], e[6], e[7]};
        n_keys = {e[4], e[5], e[6], e[7], e[8], e[9], e[10], e[11]};
        nr     = num_rounds(i_ctl.mode);
        sr     = sub_shift(i_state);
        mx     = mix_columns(sr);
        if (i_round < nr) begin
            n_state = mx ^ rk;
        end else if (i_round == nr) begin
            n_state = sr ^ rk;
        end else begin
            n_state = i_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
            r_keys  <= n_keys;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_state = r_state;
    assign o_keys  = r_keys;

endmodule

`default_nettype wire

[hw/rtl/aes_block_encrypt_unit.sv]
// AES-128/192/256 block encryption, one 128-bit block per request.
// Configuration: write the key size mode (index 0) and the key words
// (indexes 1 to 4) on the cfg channel while no request is in flight;
// cfg_ready is always high and writes to other indexes are dropped.
// Input: a plaintext request is taken when i_in_valid and o_in_ready are high.
// Output: the ciphertext request stands on o_out_valid until i_out_ready.
// Path: an accepted block passes the entry stage, which adds the first
// round key, then a row of 14 round cells, and leaves from the last cell on
// o_out_valid. Throughput: one block per cycle while the receiver keeps
// i_out_ready high; each cell holds one block and expands its own round key
// on the fly, so the key schedule never holds up the row.
// Shorter keys pass the unused trailing cells unchanged, so latency is the
// same for all modes.
// Reset clears the mode and key registers and all stage valid bits.
// When the receiver stalls, the last cell holds its result and stages behind
// it keep filling until the row is full; only then does o_in_ready drop.
`default_nettype none

`include "aes_block_encrypt_unit_defines.svh"

module aes_block_encrypt_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_plaintext_high,
    input  logic [63:0] i_plaintext_low,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_ciphertext_high,
    output logic [63:0] o_ciphertext_low
);
    import aesenc_pkg::*;

    // configuration registers
    logic [1:0]   r_mode;
    logic [63:0]  r_key0, r_key1, r_key2, r_key3;

    // stage 0 is the entry register, stages 1..14 are the round cells
    t_ctl         ctl [NUM_CELLS + 1];
    logic [127:0] st  [NUM_CELLS + 1];
    logic [255:0] ks  [NUM_CELLS + 1];
    logic         en  [NUM_CELLS + 1];

    t_ctl         r_ctl0;
    logic [127:0] r_st0;
    logic [255:0] r_ks0;
    logic [31:0]  w [8];
    logic [127:0] n_st0;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_128;
            r_key0 <= '0;
            r_key1 <= '0;
            r_key2 <= '0;
            r_key3 <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:  r_mode <= i_cfg_data[1:0];
                CFG_KEY_0: r_key0 <= i_cfg_data;
                CFG_KEY_1: r_key1 <= i_cfg_data;
                CFG_KEY_2: r_key2 <= i_cfg_data;
                CFG_KEY_3: r_key3 <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // Entry: fill the first eight schedule words, then add round key zero.
    always_comb begin
        w[0] = r_key0[63:32];
        w[1] = r_key0[31:0];
        w[2] = r_key1[63:32];
        w[3] = r_key1[31:0];
        w[4] = r_key2[63:32];
        w[5] = r_key2[31:0];
        w[6] = r_key3[63:32];
        w[7] = r_key3[31:0];
        unique case (r_mode)
            MODE_128: begin
                w[4] = key_word(6'd4, r_mode, w[3], w[0]);
                w[5] = key_word(6'd5, r_mode, w[4], w[1]);
                w[6] = key_word(6'd6, r_mode, w[5], w[2]);
                w[7] = key_word(6'd7, r_mode, w[6], w[3]);
            end
            MODE_192: begin
                w[6] = key_word(6'd6, r_mode, w[5], w[0]);
                w[7] = key_word(6'd7, r_mode, w[6], w[1]);
            end
            default: ;
        endcase
        n_st0 = {i_plaintext_high, i_plaintext_low} ^ {w[0], w[1], w[2], w[3]};
    end

    // Advance a stage when it is empty or the one after it advances.
    assign en[NUM_CELLS] = !ctl[NUM_CELLS].valid || i_out_ready;
    genvar k;
    generate
        for (k = 0; k < NUM_CELLS; k++) begin : g_en
            assign en[k] = !ctl[k].valid || en[k + 1];
        end
    endgenerate

    assign o_in_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else if (en[0]) begin
            r_ctl0.valid <= i_in_valid;
            r_ctl0.mode  <= r_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_st0 <= n_st0;
            r_ks0 <= {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7]};
        end
    end

    assign ctl[0] = r_ctl0;
    assign st[0]  = r_st0;
    assign ks[0]  = r_ks0;

    generate
        for (k = 1; k <= NUM_CELLS; k++) begin : g_cell
            aesenc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_round (4'(k)),
                .i_en    (en[k]),
                .i_ctl   (ctl[k - 1]),
                .i_state (st[k - 1]),
                .i_keys  (ks[k - 1]),
                .o_ctl   (ctl[k]),
                .o_state (st[k]),
                .o_keys  (ks[k])
            );
        end
    endgenerate

    assign o_out_valid       = ctl[NUM_CELLS].valid;
    assign o_ciphertext_high = st[NUM_CELLS][127:64];
    assign o_ciphertext_low  = st[NUM_CELLS][63:0];

    // an empty output stage always lets the row move
    `AESENC_ASSERT_NOW(a_ready_when_out_empty, !o_out_valid, o_in_ready)
    // a request held in the entry stage is not lost while it waits
    `AESENC_ASSERT_NEXT(a_entry_holds, r_ctl0.valid && !en[1], r_ctl0.valid)
    // input stalls only with the entry full and the next cell blocked
    `AESENC_ASSERT_NOW(a_stall_cause, !o_in_ready, r_ctl0.valid && !en[1])

endmodule

`default_nettype wire
